// ===== hw/rtl/mwsg_pkg.sv =====
`timescale 1ns / 1ps

package mwsg_pkg;

    localparam int INDEX_WIDTH      = 16;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int SAMPLE_INDEX_W = 16;
    localparam int SAMPLE_VALUE_W = 16;
    localparam int IDX_USED_W     = (INDEX_WIDTH < SAMPLE_INDEX_W) ? INDEX_WIDTH : SAMPLE_INDEX_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int SINE_IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SINE_PROD_W = 30 + SINE_IDX_W;

    localparam int OP_W   = 34;
    localparam int PROD_W = 50;

    localparam logic [15:0] DUTY_MIN = 16'd66;
    localparam logic [15:0] DUTY_MAX = 16'd65470;
    localparam logic [16:0] UNIT     = 17'd32767;
    localparam logic [16:0] UNIT_X2  = 17'd65534;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAVE_MODE   = 3'd0,
        CFG_PHASE_STEP  = 3'd1,
        CFG_AMPLITUDE   = 3'd2,
        CFG_DUTY_CYCLE  = 3'd3,
        CFG_SINE_OFFSET = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_PULSE    = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_mode_t;

    typedef struct packed {
        wave_mode_t         wave_mode;
        logic [31:0]        phase_step;
        logic signed [15:0] amplitude;
        logic [15:0]        duty_cycle;
        logic [15:0]        sine_phase_offset;
    } cfg_t;

    typedef struct packed {
        logic signed [OP_W-1:0] op;
        logic                   is_sine;
    } shape_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic                     is_sine;
    } scaled_t;

    typedef logic [SINE_TABLE_DEPTH:0][14:0] sine_tbl_t;

    function automatic longint unsigned taylor_pow2(longint unsigned t, longint unsigned x);
        longint unsigned r;
        r = (t * x) >> 30;
        r = (r * x) >> 30;
        return r;
    endfunction

    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t         tbl;
        longint unsigned   x;
        longint unsigned   t;
        longint unsigned   v;
        longint            sum;
        tbl = '0;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x   = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
            t   = x;
            sum = longint'(x);
            t = taylor_pow2(t, x) / 6;    sum = sum - longint'(t);
            t = taylor_pow2(t, x) / 20;   sum = sum + longint'(t);
            t = taylor_pow2(t, x) / 42;   sum = sum - longint'(t);
            t = taylor_pow2(t, x) / 72;   sum = sum + longint'(t);
            t = taylor_pow2(t, x) / 110;  sum = sum - longint'(t);
            t = taylor_pow2(t, x) / 156;  sum = sum + longint'(t);
            t = taylor_pow2(t, x) / 210;  sum = sum - longint'(t);
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (longint'(sum) * 32767 + 64'd536870912) >> 30;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            tbl[k] = v[14:0];
        end
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage

// ===== hw/rtl/multi_waveform_sample_generator_core.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in        to core    in_valid / in_stall  sample_index [15:0]
// out       from core  out_valid / out_stall sample_value [15:0] signed
// cfg       to core    cfg_valid / cfg_ready cfg_index [2:0], cfg_data [31:0]
//
// One transfer per cycle per side unless stalled; stages: phase multiply,
// wave shaping with sine lookup, amplitude multiply, rounding, output register.
// Reset clears all valid bits and loads the default register values.
// A stall propagates backwards stage by stage; bubbles are squeezed out.

module multi_waveform_sample_generator_core
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic [mwsg_pkg::SAMPLE_INDEX_W-1:0]        sample_index,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [mwsg_pkg::SAMPLE_VALUE_W-1:0] sample_value,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [mwsg_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  logic [mwsg_pkg::CFG_DATA_W-1:0]            cfg_data
);

    mwsg_pkg::cfg_t    cfg;
    logic              ph_ready;
    logic              ph_valid;
    logic [31:0]       frac;
    logic              sh_ready;
    logic              sh_valid;
    mwsg_pkg::shape_t  shape;
    logic              sc_ready;
    logic              sc_valid;
    mwsg_pkg::scaled_t scaled;
    logic              rd_ready;

    assign in_stall = !ph_ready;

    mwsg_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mwsg_phase u_phase
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (in_valid),
        .up_ready     (ph_ready),
        .sample_index (sample_index),
        .phase_step   (cfg.phase_step),
        .dn_valid     (ph_valid),
        .dn_ready     (sh_ready),
        .frac         (frac)
    );

    mwsg_shape u_shape
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ph_valid),
        .up_ready (sh_ready),
        .frac     (frac),
        .cfg      (cfg),
        .dn_valid (sh_valid),
        .dn_ready (sc_ready),
        .shape    (shape)
    );

    mwsg_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (sh_valid),
        .up_ready  (sc_ready),
        .shape     (shape),
        .amplitude (cfg.amplitude),
        .dn_valid  (sc_valid),
        .dn_ready  (rd_ready),
        .scaled    (scaled)
    );

    mwsg_round u_round
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (sc_valid),
        .up_ready     (rd_ready),
        .scaled       (scaled),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value)
    );

endmodule

// ===== hw/rtl/mwsg_cfg_regs.sv =====
`timescale 1ns / 1ps

module mwsg_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mwsg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mwsg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mwsg_pkg::cfg_t                     cfg
);

    mwsg_pkg::cfg_t cfg_reg;
    mwsg_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (mwsg_pkg::cfg_reg_t'(cfg_index))
                mwsg_pkg::CFG_WAVE_MODE:   cfg_next.wave_mode = mwsg_pkg::wave_mode_t'(cfg_data[1:0]);
                mwsg_pkg::CFG_PHASE_STEP:  cfg_next.phase_step = cfg_data;
                mwsg_pkg::CFG_AMPLITUDE:   cfg_next.amplitude = $signed(cfg_data[15:0]);
                mwsg_pkg::CFG_DUTY_CYCLE:  cfg_next.duty_cycle = cfg_data[15:0];
                mwsg_pkg::CFG_SINE_OFFSET: cfg_next.sine_phase_offset = cfg_data[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_mode         <= mwsg_pkg::WAVE_SINE;
            cfg_reg.phase_step        <= 32'd67108864;
            cfg_reg.amplitude         <= 16'sd32767;
            cfg_reg.duty_cycle        <= 16'd32768;
            cfg_reg.sine_phase_offset <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/mwsg_phase.sv =====
`timescale 1ns / 1ps

module mwsg_phase
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 up_valid,
    output logic                                 up_ready,
    input  logic [mwsg_pkg::SAMPLE_INDEX_W-1:0]  sample_index,
    input  logic [31:0]                          phase_step,
    output logic                                 dn_valid,
    input  logic                                 dn_ready,
    output logic [31:0]                          frac
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] frac_reg;
    logic [31:0] frac_next;
    logic        load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign frac     = frac_reg;

    always_comb
    begin
        frac_next  = 32'(sample_index[mwsg_pkg::IDX_USED_W-1:0]) * phase_step;
        valid_next = load ? 1'b1 : (dn_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frac_reg <= frac_next;
        end
    end

endmodule

// ===== hw/rtl/mwsg_shape.sv =====
`timescale 1ns / 1ps

module mwsg_shape
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic [31:0]         frac,
    input  mwsg_pkg::cfg_t      cfg,
    output logic                dn_valid,
    input  logic                dn_ready,
    output mwsg_pkg::shape_t    shape
);

    localparam logic signed [35:0] ONE_CYCLE = 36'sh1_0000_0000;
    localparam logic signed [mwsg_pkg::OP_W-1:0] POS_FULL = 34'sh1_0000_0000;
    localparam logic signed [mwsg_pkg::OP_W-1:0] NEG_FULL = -34'sh1_0000_0000;

    logic             valid_reg;
    logic             valid_next;
    mwsg_pkg::shape_t shape_reg;
    mwsg_pkg::shape_t shape_next;
    logic             load;

    logic [31:0]                           ph;
    logic [mwsg_pkg::SINE_PROD_W-1:0]      pos_wide;
    logic [mwsg_pkg::SINE_IDX_W-1:0]       pos;
    logic [mwsg_pkg::SINE_IDX_W-1:0]       tidx;
    logic signed [15:0]                    sine_val;
    logic [15:0]                           duty;
    logic [31:0]                           g;
    logic signed [35:0]                    e;
    logic signed [35:0]                    e_abs;
    logic signed [35:0]                    tri_n;
    logic signed [35:0]                    saw_d;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign shape    = shape_reg;

    always_comb
    begin
        ph       = frac + {1'b0, cfg.sine_phase_offset, 15'd0};
        pos_wide = mwsg_pkg::SINE_PROD_W'(ph[29:0])
                   * mwsg_pkg::SINE_PROD_W'(mwsg_pkg::SINE_TABLE_DEPTH)
                   + mwsg_pkg::SINE_PROD_W'(32'h2000_0000);
        pos      = pos_wide[mwsg_pkg::SINE_PROD_W-1:30];
        tidx     = ph[30] ? (mwsg_pkg::SINE_IDX_W'(mwsg_pkg::SINE_TABLE_DEPTH) - pos) : pos;
        sine_val = $signed({1'b0, mwsg_pkg::SINE_TBL[tidx]});
        if (ph[31])
        begin
            sine_val = -sine_val;
        end

        duty = cfg.duty_cycle;
        if (duty < mwsg_pkg::DUTY_MIN)
        begin
            duty = mwsg_pkg::DUTY_MIN;
        end
        if (duty > mwsg_pkg::DUTY_MAX)
        begin
            duty = mwsg_pkg::DUTY_MAX;
        end

        saw_d = $signed({3'd0, frac, 1'b0}) - ONE_CYCLE;

        g     = frac + 32'h4000_0000;
        e     = $signed({3'd0, g, 1'b0}) - ONE_CYCLE;
        e_abs = (e < 0) ? -e : e;
        tri_n = ONE_CYCLE - (e_abs <<< 1);

        shape_next.is_sine = 1'b0;
        case (cfg.wave_mode)
            mwsg_pkg::WAVE_SINE:
            begin
                shape_next.op      = mwsg_pkg::OP_W'(sine_val);
                shape_next.is_sine = 1'b1;
            end
            mwsg_pkg::WAVE_PULSE:
                shape_next.op = (frac < {duty, 16'd0}) ? POS_FULL : NEG_FULL;
            mwsg_pkg::WAVE_SAW:
                shape_next.op = saw_d[mwsg_pkg::OP_W-1:0];
            mwsg_pkg::WAVE_TRIANGLE:
                shape_next.op = tri_n[mwsg_pkg::OP_W-1:0];
            default:
                shape_next.op = '0;
        endcase

        valid_next = load ? 1'b1 : (dn_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shape_reg <= shape_next;
        end
    end

endmodule

// ===== hw/rtl/mwsg_scale.sv =====
`timescale 1ns / 1ps

module mwsg_scale
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  mwsg_pkg::shape_t     shape,
    input  logic signed [15:0]   amplitude,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output mwsg_pkg::scaled_t    scaled
);

    logic              valid_reg;
    logic              valid_next;
    mwsg_pkg::scaled_t scaled_reg;
    mwsg_pkg::scaled_t scaled_next;
    logic              load;
    logic signed [15:0] amp;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign scaled   = scaled_reg;

    always_comb
    begin
        amp = (amplitude == -16'sd32768) ? -16'sd32767 : amplitude;
        scaled_next.prod    = mwsg_pkg::PROD_W'(amp) * mwsg_pkg::PROD_W'(shape.op);
        scaled_next.is_sine = shape.is_sine;
        valid_next = load ? 1'b1 : (dn_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scaled_reg <= scaled_next;
        end
    end

endmodule

// ===== hw/rtl/mwsg_round.sv =====
`timescale 1ns / 1ps

module mwsg_round
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       up_valid,
    output logic                                       up_ready,
    input  mwsg_pkg::scaled_t                          scaled,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [mwsg_pkg::SAMPLE_VALUE_W-1:0] sample_value
);

    // rounding prep stage
    logic        rv_reg;
    logic        rv_next;
    logic        neg_reg;
    logic        sine_reg;
    logic [15:0] q_reg;
    logic [16:0] rem_reg;
    logic        neg_next;
    logic [15:0] q_next;
    logic [16:0] rem_next;
    logic        r_ready;
    logic        r_load;

    logic [mwsg_pkg::PROD_W-1:0] mag;
    logic [47:0]                 shift_sum;
    logic [30:0]                 x;

    // output stage
    logic                                       ov_reg;
    logic                                       ov_next;
    logic signed [mwsg_pkg::SAMPLE_VALUE_W-1:0] value_reg;
    logic signed [mwsg_pkg::SAMPLE_VALUE_W-1:0] value_next;
    logic                                       o_ready;
    logic                                       o_load;
    logic [16:0]                                q_fin;

    assign o_ready      = !ov_reg || !out_stall;
    assign r_ready      = !rv_reg || o_ready;
    assign up_ready     = r_ready;
    assign r_load       = up_valid && r_ready;
    assign o_load       = rv_reg && o_ready;
    assign out_valid    = ov_reg;
    assign sample_value = value_reg;

    always_comb
    begin
        neg_next  = scaled.prod[mwsg_pkg::PROD_W-1];
        mag       = neg_next ? -scaled.prod : scaled.prod;
        shift_sum = mag[47:0] + 48'h0000_8000_0000;
        x         = {1'b0, mag[29:0]} + 31'd16383;
        if (scaled.is_sine)
        begin
            q_next   = {1'b0, x[29:15]};
            rem_next = {2'd0, x[14:0]} + {1'b0, x[30:15]};
        end
        else
        begin
            q_next   = shift_sum[47:32];
            rem_next = '0;
        end
        rv_next = r_load ? 1'b1 : (o_ready ? 1'b0 : rv_reg);
    end

    always_comb
    begin
        q_fin = {1'b0, q_reg};
        if (sine_reg)
        begin
            q_fin = {1'b0, q_reg} + 17'(rem_reg >= mwsg_pkg::UNIT)
                    + 17'(rem_reg >= mwsg_pkg::UNIT_X2);
        end
        if (q_fin > mwsg_pkg::UNIT)
        begin
            q_fin = mwsg_pkg::UNIT;
        end
        value_next = neg_reg ? -$signed(q_fin[15:0]) : $signed(q_fin[15:0]);
        ov_next    = o_load ? 1'b1 : (out_stall ? ov_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= rv_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_load)
        begin
            neg_reg  <= neg_next;
            sine_reg <= scaled.is_sine;
            q_reg    <= q_next;
            rem_reg  <= rem_next;
        end
        if (o_load)
        begin
            value_reg <= value_next;
        end
    end

endmodule

// ===== tb/multi_waveform_sample_generator_core_test.sv =====
`timescale 1ns / 1ps

module multi_waveform_sample_generator_core_test;

    import mwsg_pkg::*;

    localparam int AMP_PEAK     = 32767;
    localparam int DUTY_FLOOR   = 66;
    localparam int DUTY_CEIL    = 65470;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 16;
    localparam int RANDOM_ITEMS = 874;
    localparam int CALM_ITEMS   = 150;
    localparam int unsigned CYCLE_LIMIT = 500000;

    localparam longint FULL_TURN             = 64'sh1_0000_0000;
    localparam longint unsigned HALF_TURN    = 64'h8000_0000;
    localparam logic [31:0] QUARTER_TURN     = 32'h4000_0000;
    localparam longint unsigned HALF_PI_FIX  = 64'd1686629713;
    localparam longint unsigned Q30_HALF     = 64'd536870912;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd5;

    typedef struct packed {
        logic               keep;
        wave_mode_t         mode;
        logic [31:0]        step;
        logic signed [15:0] amp;
        logic [15:0]        duty;
        logic [15:0]        ofs;
        logic [15:0]        idx;
        logic               pin;
        logic signed [15:0] want;
    } probe_t;

    localparam probe_t PROBES [0:25] = '{
        '{1'b1, WAVE_SINE,     32'h0400_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h0010, 1'b1,  16'sd32767},
        '{1'b1, WAVE_SINE,     32'h0400_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h0000, 1'b1,  16'sd0},
        '{1'b0, WAVE_SINE,     32'h4000_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h0001, 1'b1,  16'sd32767},
        '{1'b0, WAVE_SINE,     32'h4000_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h0003, 1'b1, -16'sd32767},
        '{1'b0, WAVE_SINE,     32'h0000_0000,  16'sd32767, 16'h8000, 16'h8000, 16'hFFFF, 1'b1,  16'sd32767},
        '{1'b0, WAVE_SINE,     32'hFFFF_FFFF,  16'sh8000,  16'h8000, 16'hFFFF, 16'hFFFF, 1'b0,  16'sd0},
        '{1'b0, WAVE_SINE,     32'h0000_0001, -16'sd1,     16'h0000, 16'h1234, 16'hFFFF, 1'b0,  16'sd0},
        '{1'b0, WAVE_SINE,     32'h0123_4567,  16'sd12345, 16'h0000, 16'h4000, 16'h00A5, 1'b0,  16'sd0},
        '{1'b0, WAVE_PULSE,    32'h0400_0000,  16'sh8000,  16'h8000, 16'h0000, 16'h0000, 1'b1, -16'sd32767},
        '{1'b0, WAVE_PULSE,    32'h0400_0000,  16'sd32767, 16'h0000, 16'h0000, 16'h0000, 1'b1,  16'sd32767},
        '{1'b0, WAVE_PULSE,    32'h0400_0000,  16'sd32767, 16'h0000, 16'h0000, 16'h0001, 1'b1, -16'sd32767},
        '{1'b0, WAVE_PULSE,    32'hFFFF_FFFF,  16'sd32767, 16'hFFFF, 16'h0000, 16'h0001, 1'b1, -16'sd32767},
        '{1'b0, WAVE_PULSE,    32'hFFFF_FFFF,  16'sd1000,  16'hFFBE, 16'h0000, 16'hFFFF, 1'b0,  16'sd0},
        '{1'b0, WAVE_PULSE,    32'h0000_0001, -16'sd5,     16'h0041, 16'h0000, 16'h0041, 1'b0,  16'sd0},
        '{1'b0, WAVE_SAW,      32'h0400_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h0000, 1'b1, -16'sd32767},
        '{1'b0, WAVE_SAW,      32'h0400_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h0020, 1'b1,  16'sd0},
        '{1'b0, WAVE_SAW,      32'h0400_0000,  16'sd0,     16'h8000, 16'h0000, 16'hFFFF, 1'b1,  16'sd0},
        '{1'b0, WAVE_SAW,      32'hFFFF_FFFF,  16'sh8000,  16'h8000, 16'h0000, 16'hFFFF, 1'b0,  16'sd0},
        '{1'b0, WAVE_SAW,      32'h0000_1000,  16'sd1,     16'h8000, 16'h0000, 16'h8001, 1'b0,  16'sd0},
        '{1'b0, WAVE_SAW,      32'h0765_4321,  16'sd32767, 16'h8000, 16'hFFFF, 16'h5A5A, 1'b0,  16'sd0},
        '{1'b0, WAVE_TRIANGLE, 32'h0400_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h0000, 1'b1,  16'sd0},
        '{1'b0, WAVE_TRIANGLE, 32'h0400_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h0010, 1'b1,  16'sd32767},
        '{1'b0, WAVE_TRIANGLE, 32'h0400_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h0030, 1'b1, -16'sd32767},
        '{1'b0, WAVE_TRIANGLE, 32'h0400_0000, -16'sd32767, 16'h8000, 16'h0000, 16'h0010, 1'b1, -16'sd32767},
        '{1'b0, WAVE_TRIANGLE, 32'h89AB_CDEF,  16'sh8000,  16'h8000, 16'h0000, 16'hFFFF, 1'b0,  16'sd0},
        '{1'b0, WAVE_TRIANGLE, 32'h0000_0000,  16'sd32767, 16'h8000, 16'h0000, 16'h7FFF, 1'b1,  16'sd0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [SAMPLE_INDEX_W-1:0] sample_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SAMPLE_VALUE_W-1:0] sample_value;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the register file
    wave_mode_t         model_mode = WAVE_SINE;
    logic [31:0]        model_step = 32'h0400_0000;
    logic signed [15:0] model_amp  = 16'sd32767;
    logic [15:0]        model_duty = 16'h8000;
    logic [15:0]        model_ofs  = 16'h0000;

    int sine_quarter [0:SINE_TABLE_DEPTH];

    logic signed [15:0] pending_samples [$];
    logic               pinned = 1'b0;
    logic signed [15:0] pinned_value = '0;
    bit                 jitter_on = 1'b0;
    bit                 long_hold_req = 1'b0;
    logic [15:0]        walk_index = '0;
    int                 mismatches = 0;
    int unsigned        cycle_count = 0;

    multi_waveform_sample_generator_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_index (sample_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint round_turn(input longint p);
        longint unsigned mag;
        longint q;
        mag = (p < 0) ? -p : p;
        q = longint'((mag + HALF_TURN) >> 32);
        return (p < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] predict_sample(input logic [15:0] idx);
        logic [63:0]       wide;
        logic [31:0]       frac;
        logic [31:0]       ph;
        logic [15:0]       duty;
        longint            a;
        longint            prod;
        longint            lin;
        longint            q;
        longint unsigned   mag;
        longint unsigned   tix;
        int                s;
        wide = 64'(idx) * 64'(model_step);
        frac = wide[31:0];
        a = (model_amp < -AMP_PEAK) ? -AMP_PEAK : longint'(model_amp);
        case (model_mode)
            WAVE_SINE:
            begin
                ph = frac + {1'b0, model_ofs, 15'd0};
                tix = (longint'(ph[29:0]) * SINE_TABLE_DEPTH + Q30_HALF) >> 30;
                if (tix > SINE_TABLE_DEPTH)
                begin
                    tix = SINE_TABLE_DEPTH;
                end
                s = ph[30] ? sine_quarter[SINE_TABLE_DEPTH - tix] : sine_quarter[tix];
                if (ph[31])
                begin
                    s = -s;
                end
                prod = a * s;
                mag = (prod < 0) ? -prod : prod;
                q = longint'((mag + AMP_PEAK / 2) / AMP_PEAK);
                lin = (prod < 0) ? -q : q;
            end
            WAVE_PULSE:
            begin
                duty = model_duty;
                if (duty < DUTY_FLOOR)
                begin
                    duty = DUTY_FLOOR;
                end
                if (duty > DUTY_CEIL)
                begin
                    duty = DUTY_CEIL;
                end
                lin = (frac < {duty, 16'd0}) ? a : -a;
            end
            WAVE_SAW:
            begin
                lin = round_turn(a * (2 * longint'(frac) - FULL_TURN));
            end
            default:
            begin
                ph = frac + QUARTER_TURN;
                prod = 2 * longint'(ph) - FULL_TURN;
                if (prod < 0)
                begin
                    prod = -prod;
                end
                lin = round_turn(a * (FULL_TURN - 2 * prod));
            end
        endcase
        if (lin > AMP_PEAK)
        begin
            lin = AMP_PEAK;
        end
        if (lin < -AMP_PEAK)
        begin
            lin = -AMP_PEAK;
        end
        return 16'(lin);
    endfunction

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d samples pending", $time, pending_samples.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            pending_samples.push_back(pinned ? pinned_value : predict_sample(sample_index));
        end
    end

    always @(posedge clk)
    begin : check_out
        logic signed [15:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t: sample_value %0d with nothing pending", $time, sample_value);
                mismatches++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample_value !== want)
                begin
                    $display("%0t: sample_value expected %0d actual %0d",
                             $time, want, sample_value);
                    mismatches++;
                end
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (jitter_on && $urandom_range(0, 7) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic offer_index(input logic [15:0] idx, input logic pin,
                               input logic signed [15:0] pin_val);
        sample_index = idx;
        pinned = pin;
        pinned_value = pin_val;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] ridx, input logic [31:0] data);
        cfg_index = ridx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (ridx)
            CFG_WAVE_MODE:   model_mode = wave_mode_t'(data[1:0]);
            CFG_PHASE_STEP:  model_step = data;
            CFG_AMPLITUDE:   model_amp  = data[15:0];
            CFG_DUTY_CYCLE:  model_duty = data[15:0];
            CFG_SINE_OFFSET: model_ofs  = data[15:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setup(input wave_mode_t mode, input logic [31:0] step,
                               input logic signed [15:0] amp, input logic [15:0] duty,
                               input logic [15:0] ofs);
        logic [31:0] junk;
        drain();
        junk = $urandom;
        write_reg(CFG_WAVE_MODE, {junk[31:2], mode});
        write_reg(CFG_PHASE_STEP, step);
        junk = $urandom;
        write_reg(CFG_AMPLITUDE, {junk[31:16], amp});
        junk = $urandom;
        write_reg(CFG_DUTY_CYCLE, {junk[31:16], duty});
        junk = $urandom;
        write_reg(CFG_SINE_OFFSET, {junk[31:16], ofs});
        write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE, 2 ** CFG_INDEX_W - 1)), $urandom);
    endtask

    task automatic run_burst(input int count);
        logic [15:0] idx;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 3))
                0: idx = 16'($urandom_range(0, 63));
                1: idx = 16'hFFFF - 16'($urandom_range(0, 63));
                2:
                begin
                    idx = walk_index;
                    walk_index = walk_index + 1'b1;
                end
                default: idx = 16'($urandom);
            endcase
            offer_index(idx, 1'b0, '0);
            if (jitter_on && $urandom_range(0, 5) == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        longint unsigned    x;
        longint unsigned    t;
        longint unsigned    v;
        longint             acc;
        int                 random_sent;
        int                 burst;
        int                 phase;
        wave_mode_t         r_mode;
        logic [31:0]        r_step;
        logic signed [15:0] r_amp;
        logic [15:0]        r_duty;
        logic [15:0]        r_ofs;

        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x = (HALF_PI_FIX * k) / SINE_TABLE_DEPTH;
            t = x;
            acc = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / ((2 * n) * (2 * n + 1));
                acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            v = (acc * AMP_PEAK + Q30_HALF) >> 30;
            sine_quarter[k] = (v > AMP_PEAK) ? AMP_PEAK : int'(v);
        end

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (PROBES[i])
        begin
            if (!PROBES[i].keep)
            begin
                apply_setup(PROBES[i].mode, PROBES[i].step, PROBES[i].amp,
                            PROBES[i].duty, PROBES[i].ofs);
            end
            offer_index(PROBES[i].idx, PROBES[i].pin, PROBES[i].want);
        end

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            r_mode = wave_mode_t'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: r_step = 32'd1;
                1: r_step = 32'hFFFF_FFFF;
                2: r_step = 32'd1 << $urandom_range(10, 31);
                3: r_step = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
                default: r_step = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0: r_amp = 16'sd32767;
                1: r_amp = 16'sh8000;
                2: r_amp = -16'sd32767;
                3: r_amp = 16'($urandom_range(0, 2)) - 16'sd1;
                default: r_amp = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: r_duty = 16'($urandom_range(0, DUTY_FLOOR));
                1: r_duty = 16'($urandom_range(DUTY_CEIL, 65535));
                default: r_duty = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: r_ofs = 16'h0000;
                1: r_ofs = 16'hFFFF;
                default: r_ofs = 16'($urandom);
            endcase
            apply_setup(r_mode, r_step, r_amp, r_duty, r_ofs);

            jitter_on = ($urandom_range(0, 3) != 0);
            burst = $urandom_range(20, 80);
            if (phase == 2)
            begin
                // sender keeps offering while the output is held
                jitter_on = 1'b0;
                long_hold_req = 1'b1;
                burst = 60;
            end
            if (burst > RANDOM_ITEMS - random_sent)
            begin
                burst = RANDOM_ITEMS - random_sent;
            end
            run_burst(burst);
            random_sent = random_sent + burst;
            phase = phase + 1;
        end

        jitter_on = 1'b0;
        run_burst(CALM_ITEMS);

        drain();
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
